// ----- hdl/fna_pkg.sv -----
`timescale 1ns / 1ps
package fna_pkg;

	localparam int NORM_WIDTH = 24;

	typedef struct packed {
		logic accept;
		logic step;
		logic load_out;
	} fna_cmd_t;

	typedef struct packed {
		logic last_done;
	} fna_sts_t;

endpackage

// ----- hdl/fna_if.sv -----
`timescale 1ns / 1ps
interface fna_in_if #(
	parameter int SAMPLE_WIDTH = 16
) ();
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] element;
	logic                           last;

	modport source (output valid, output element, output last, input ready);
	modport sink (input valid, input element, input last, output ready);
endinterface

interface fna_out_if ();
	import fna_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [NORM_WIDTH-1:0] norm;
	logic                  overflow;

	modport source (output valid, output norm, output overflow, input ready);
	modport sink (input valid, input norm, input overflow, output ready);
endinterface

// ----- hdl/frobenius_norm_accumulator_top.sv -----
`timescale 1ns / 1ps
// channel   modport  payload                         transfer
// samples   sink     element[SAMPLE_WIDTH], last     valid && ready
// result    source   norm[24], overflow              valid && ready
//
// elements not marked last are taken one per cycle
// after a last element ready stays low while the two-stage square pipeline drains,
// the one-digit-per-cycle root runs and the result register is loaded
// the result register holds a finished norm while the next matrix streams in
// a second root waits in place until the previous result has been taken
// asynchronous reset clears sum and flag at once, no clearing pass
module frobenius_norm_accumulator_top #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int ACC_WIDTH    = 48
) (
	input  logic      clk,
	input  logic      arst_n,
	fna_in_if.sink    samples,
	fna_out_if.source result
);
	import fna_pkg::*;

	localparam int STEPS = (ACC_WIDTH + 1) / 2;

	fna_cmd_t cmd;
	fna_sts_t sts;

	fna_ctrl #(
		.STEPS(STEPS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (samples.valid),
		.in_last  (samples.last),
		.in_ready (samples.ready),
		.out_ready(result.ready),
		.out_valid(result.valid),
		.sts      (sts),
		.cmd      (cmd)
	);

	fna_datapath #(
		.SAMPLE_WIDTH(SAMPLE_WIDTH),
		.ACC_WIDTH   (ACC_WIDTH),
		.STEPS       (STEPS)
	) u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.element (samples.element),
		.last    (samples.last),
		.cmd     (cmd),
		.sts     (sts),
		.norm    (result.norm),
		.overflow(result.overflow)
	);
endmodule

// ----- hdl/fna_ctrl.sv -----
`timescale 1ns / 1ps
module fna_ctrl #(
	parameter int STEPS = 24
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_last,
	output logic              in_ready,
	input  logic              out_ready,
	output logic              out_valid,
	input  fna_pkg::fna_sts_t sts,
	output fna_pkg::fna_cmd_t cmd
);
	import fna_pkg::*;

	localparam int CW = $clog2(STEPS + 1);

	typedef enum logic [1:0] {
		ST_ACC,
		ST_DRAIN,
		ST_ROOT,
		ST_FINISH
	} state_t;

	state_t          state_q;
	logic [CW-1:0]   cnt_q;
	logic            out_valid_q;
	logic            accept;
	logic            load;

	assign in_ready     = (state_q == ST_ACC);
	assign accept       = in_valid && in_ready;
	assign load         = (state_q == ST_FINISH) && (!out_valid_q || out_ready);
	assign cmd.accept   = accept;
	assign cmd.step     = (state_q == ST_ROOT);
	assign cmd.load_out = load;
	assign out_valid    = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_ACC;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_ACC: begin
					if (accept && in_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					cnt_q <= '0;
					if (sts.last_done) begin
						state_q <= ST_ROOT;
					end
				end
				ST_ROOT: begin
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(STEPS - 1)) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (load) begin
						state_q <= ST_ACC;
					end
				end
				default: state_q <= ST_ACC;
			endcase
		end
	end
endmodule

// ----- hdl/fna_datapath.sv -----
`timescale 1ns / 1ps
module fna_datapath #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int ACC_WIDTH    = 48,
	parameter int STEPS        = 24
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic signed [SAMPLE_WIDTH-1:0]   element,
	input  logic                             last,
	input  fna_pkg::fna_cmd_t                cmd,
	output fna_pkg::fna_sts_t                sts,
	output logic [fna_pkg::NORM_WIDTH-1:0]   norm,
	output logic                             overflow
);
	import fna_pkg::*;

	localparam int SQW = 2 * SAMPLE_WIDTH;
	localparam int EW  = ((ACC_WIDTH > SQW) ? ACC_WIDTH : SQW) + 1;
	localparam int XW  = 2 * STEPS;
	localparam int RW  = (STEPS > NORM_WIDTH) ? STEPS : NORM_WIDTH;

	logic                    valid_s1, valid_s2;
	logic                    last_s1, last_s2;
	logic [SAMPLE_WIDTH-1:0] mag_s1;
	logic [SQW-1:0]          sq_s2;
	logic [SAMPLE_WIDTH-1:0] mag;
	logic [ACC_WIDTH-1:0]    sum_q;
	logic                    sat_q;
	logic [EW-1:0]           total;
	logic                    clip;
	logic [ACC_WIDTH-1:0]    new_sum;
	logic                    new_sat;
	logic [XW-1:0]           x_q;
	logic [STEPS:0]          rem_q;
	logic [STEPS-1:0]        root_q;
	logic                    flag_q;
	logic [STEPS+2:0]        rem_sh;
	logic [STEPS+2:0]        trial;
	logic                    take;
	logic [RW-1:0]           root_w;
	logic [NORM_WIDTH-1:0]   norm_q;
	logic                    ovf_q;

	assign mag = element[SAMPLE_WIDTH-1] ? (~element + SAMPLE_WIDTH'(1)) : element;

	assign total   = EW'(sum_q) + EW'(sq_s2);
	assign clip    = total > EW'({ACC_WIDTH{1'b1}});
	assign new_sum = clip ? {ACC_WIDTH{1'b1}} : total[ACC_WIDTH-1:0];
	assign new_sat = sat_q | clip;

	assign sts.last_done = valid_s2 && last_s2;

	assign rem_sh = {rem_q[STEPS:0], x_q[XW-1 -: 2]};
	assign trial  = {1'b0, root_q, 2'b01};
	assign take   = rem_sh >= trial;
	assign root_w = RW'(root_q);

	assign norm     = norm_q;
	assign overflow = ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			sum_q    <= '0;
			sat_q    <= 1'b0;
		end else begin
			valid_s1 <= cmd.accept;
			valid_s2 <= valid_s1;
			if (valid_s2) begin
				if (last_s2) begin
					sum_q <= '0;
					sat_q <= 1'b0;
				end else begin
					sum_q <= new_sum;
					sat_q <= new_sat;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		mag_s1  <= mag;
		last_s1 <= last;
		sq_s2   <= SQW'(mag_s1) * SQW'(mag_s1);
		last_s2 <= last_s1;
		if (valid_s2 && last_s2) begin
			x_q    <= XW'(new_sum);
			rem_q  <= '0;
			root_q <= '0;
			flag_q <= new_sat;
		end else if (cmd.step) begin
			x_q <= x_q << 2;
			if (take) begin
				rem_q  <= (STEPS+1)'(rem_sh - trial);
				root_q <= {root_q[STEPS-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh[STEPS:0];
				root_q <= {root_q[STEPS-2:0], 1'b0};
			end
		end
		if (cmd.load_out) begin
			norm_q <= (root_w > RW'({NORM_WIDTH{1'b1}})) ? {NORM_WIDTH{1'b1}}
				: root_w[NORM_WIDTH-1:0];
			ovf_q  <= flag_q;
		end
	end
endmodule

// ----- hdl/fna_checker.sv -----
`timescale 1ns / 1ps
module fna_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        in_last,
	input logic        out_valid,
	input logic        out_ready,
	input logic [23:0] norm,
	input logic        overflow
);
	logic in_acc;

	assign in_acc = in_valid && in_ready;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(norm) && $stable(overflow))
		else $error("result changed while stalled");

	a_ready_drops: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && in_last |=> !in_ready)
		else $error("input taken right after a last element");

	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && in_last |=> !$rose(out_valid) ##1 !$rose(out_valid))
		else $error("result appeared before the root could finish");

	a_result_reopens_input: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("input still closed when a new result appeared");
endmodule

bind frobenius_norm_accumulator_top fna_checker u_fna_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (samples.valid),
	.in_ready (samples.ready),
	.in_last  (samples.last),
	.out_valid(result.valid),
	.out_ready(result.ready),
	.norm     (result.norm),
	.overflow (result.overflow)
);

// ----- sim/tb_frobenius_norm_accumulator_top.sv -----
`timescale 1ns / 1ps
module tb_frobenius_norm_accumulator_top;
	import fna_pkg::*;

	localparam int SAMPLE_WIDTH = 16;
	localparam int ACC_WIDTH    = 48;
	localparam int IDLE_LIMIT   = 1000;
	localparam int DRAIN_CYCLES = 40;
	localparam logic [ACC_WIDTH-1:0] ACC_FULL = {ACC_WIDTH{1'b1}};
	localparam logic [NORM_WIDTH-1:0] NORM_FULL = {NORM_WIDTH{1'b1}};
	localparam int LARGE_COUNT  = 256;

	typedef struct {
		logic [NORM_WIDTH-1:0] norm;
		logic                  overflow;
	} norm_result_t;

	logic clk;
	logic arst_n;

	fna_in_if #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) samples_if ();
	fna_out_if result_if ();

	frobenius_norm_accumulator_top #(
		.SAMPLE_WIDTH(SAMPLE_WIDTH),
		.ACC_WIDTH   (ACC_WIDTH)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.samples(samples_if),
		.result(result_if)
	);

	logic [ACC_WIDTH-1:0] square_sum;
	logic                 sum_clipped;
	norm_result_t         expected_norms[$];
	int                   mismatches;
	int                   idle_cycles;
	int                   ready_hold;
	logic                 result_taken;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic logic [NORM_WIDTH-1:0] floor_root(input logic [ACC_WIDTH-1:0] x);
		logic [63:0] rem;
		logic [63:0] root;
		logic [63:0] b;
		rem  = 64'(x);
		root = 64'd0;
		b    = 64'd1 << 62;
		while (b != 0) begin
			if (rem >= root + b) begin
				rem  = rem - (root + b);
				root = (root >> 1) + b;
			end else begin
				root = root >> 1;
			end
			b = b >> 2;
		end
		if (root > 64'(NORM_FULL))
			root = 64'(NORM_FULL);
		return root[NORM_WIDTH-1:0];
	endfunction

	// update the running sum for one accepted element; on a last element queue the expected result and clear the sum
	task automatic accumulate_element(input logic signed [SAMPLE_WIDTH-1:0] value,
			input logic is_last);
		logic [SAMPLE_WIDTH:0]   mag;
		logic [ACC_WIDTH-1:0]    sq;
		logic [ACC_WIDTH:0]      total;
		norm_result_t            res;
		mag   = value[SAMPLE_WIDTH-1] ? -{value[SAMPLE_WIDTH-1], value} : {1'b0, value};
		sq    = ACC_WIDTH'(mag) * ACC_WIDTH'(mag);
		total = {1'b0, square_sum} + {1'b0, sq};
		if (total > {1'b0, ACC_FULL}) begin
			square_sum  = ACC_FULL;
			sum_clipped = 1'b1;
		end else begin
			square_sum = total[ACC_WIDTH-1:0];
		end
		if (is_last) begin
			res.norm     = floor_root(square_sum);
			res.overflow = sum_clipped;
			expected_norms.push_back(res);
			square_sum  = '0;
			sum_clipped = 1'b0;
		end
	endtask

	task automatic send_element(input logic signed [SAMPLE_WIDTH-1:0] value,
			input logic is_last, input int gap);
		@(negedge clk);
		if (gap > 0) begin
			samples_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		samples_if.valid   <= 1'b1;
		samples_if.element <= value;
		samples_if.last    <= is_last;
		do @(posedge clk); while (!samples_if.ready);
		accumulate_element(value, is_last);
	endtask

	function automatic logic signed [SAMPLE_WIDTH-1:0] pick_element();
		logic [31:0] r;
		r = $urandom();
		case ($urandom_range(0, 9))
			0: begin
				case (r[2:0])
					3'd0:    return SAMPLE_WIDTH'(-(1 <<< (SAMPLE_WIDTH - 1)));
					3'd1:    return SAMPLE_WIDTH'((1 << (SAMPLE_WIDTH - 1)) - 1);
					3'd2:    return '0;
					3'd3:    return SAMPLE_WIDTH'(-1);
					3'd4:    return SAMPLE_WIDTH'(1);
					default: return r[31:16];
				endcase
			end
			1: return r[8] ? -SAMPLE_WIDTH'(r[4:0]) : SAMPLE_WIDTH'(r[4:0]);
			default: return r[SAMPLE_WIDTH-1:0];
		endcase
	endfunction

	task automatic test_single_elements();
		send_element(16'sd0, 1'b1, $urandom_range(0, 3));
		send_element(16'sd1, 1'b1, $urandom_range(0, 3));
		send_element(-16'sd1, 1'b1, $urandom_range(0, 3));
		send_element(16'sd32767, 1'b1, $urandom_range(0, 3));
		send_element(-16'sd32768, 1'b1, $urandom_range(0, 3));
		send_element(16'sd256, 1'b1, $urandom_range(0, 3));
		send_element(-16'sd256, 1'b1, $urandom_range(0, 3));
		send_element(16'sh5555, 1'b1, $urandom_range(0, 3));
		send_element(-16'sh5556, 1'b1, $urandom_range(0, 3));
	endtask

	task automatic test_small_matrices();
		// 3-4-5 triangle in q8.8
		send_element(16'sh0300, 1'b0, $urandom_range(0, 3));
		send_element(-16'sh0400, 1'b1, $urandom_range(0, 3));
		send_element(-16'sd32768, 1'b0, 0);
		send_element(-16'sd32768, 1'b0, 0);
		send_element(16'sd32767, 1'b0, 0);
		send_element(16'sd7, 1'b1, 0);
		send_element(16'sd0, 1'b0, $urandom_range(0, 3));
		send_element(16'sd0, 1'b0, $urandom_range(0, 3));
		send_element(16'sd0, 1'b1, $urandom_range(0, 3));
		send_element(16'sd2, 1'b0, $urandom_range(0, 3));
		send_element(16'sd2, 1'b1, $urandom_range(0, 3));
	endtask

	// sum lands on all ones in its low 38 bits
	task automatic test_all_ones_sum();
		for (int k = 0; k < LARGE_COUNT - 1; k++)
			send_element(-16'sd32768, 1'b0, 0);
		send_element(16'sd32767, 1'b0, 0);
		send_element(16'sd255, 1'b0, 0);
		send_element(-16'sd22, 1'b0, 0);
		send_element(16'sd5, 1'b1, 0);
	endtask

	// long matrix of large elements, then a small one to see the sum cleared
	task automatic test_long_matrix();
		for (int k = 0; k < LARGE_COUNT; k++)
			send_element(k[0] ? 16'sd32767 : -16'sd32768, 1'b0, 0);
		send_element(16'sd1, 1'b0, 0);
		send_element(16'sd0, 1'b0, 0);
		send_element(16'sd32767, 1'b1, 0);
		send_element(16'sd3, 1'b1, $urandom_range(0, 3));
	endtask

	task automatic test_random_matrices(input int target);
		int   sent;
		int   len;
		logic quiet;
		sent = 0;
		while (sent < target) begin
			len   = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
			quiet = ($urandom_range(0, 3) == 0);
			for (int k = 0; k < len; k++) begin
				send_element(pick_element(), k == len - 1, quiet ? 0 : $urandom_range(0, 3));
				sent++;
			end
		end
		@(negedge clk);
		samples_if.valid <= 1'b0;
	endtask

	// result ready: after each transfer, ready may drop low until a randomly drawn ready_hold counts down to zero
	always @(negedge clk) begin
		if (!arst_n) begin
			result_if.ready <= 1'b0;
			ready_hold = 0;
		end else if (result_taken) begin
			result_taken = 1'b0;
			ready_hold   = $urandom_range(0, 3);
			if (ready_hold > 0)
				result_if.ready <= 1'b0;
		end else if (ready_hold > 0) begin
			ready_hold--;
			if (ready_hold == 0)
				result_if.ready <= 1'b1;
		end else begin
			result_if.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		norm_result_t want;
		if (arst_n && result_if.valid && result_if.ready) begin
			result_taken = 1'b1;
			if (expected_norms.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected result: norm=%0d overflow=%0d",
						result_if.norm, result_if.overflow);
				mismatches++;
			end else begin
				want = expected_norms.pop_front();
				if (result_if.norm !== want.norm || result_if.overflow !== want.overflow) begin
					if (mismatches < 10)
						$display("mismatch: norm exp=%0d got=%0d, overflow exp=%0d got=%0d",
							want.norm, result_if.norm, want.overflow, result_if.overflow);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((samples_if.valid && samples_if.ready) || (result_if.valid && result_if.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	initial begin
		int waited;
		arst_n             = 1'b0;
		samples_if.valid   = 1'b0;
		samples_if.element = '0;
		samples_if.last    = 1'b0;
		result_if.ready    = 1'b0;
		square_sum         = '0;
		sum_clipped        = 1'b0;
		mismatches         = 0;
		idle_cycles        = 0;
		ready_hold         = 0;
		result_taken       = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		test_single_elements();
		test_small_matrices();
		test_all_ones_sum();
		test_long_matrix();
		test_random_matrices(1320);

		waited = 0;
		while (expected_norms.size() != 0 && waited < IDLE_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_norms.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
